// ===== rtl/lrubr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU block replacement package
// Operation codes shared by the replacement policy logic.
// ----------------------------------------------------------------------------
package lrubr_pkg;

  typedef enum logic [1:0] {
    OP_TOUCH   = 2'd0,
    OP_REPLACE = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  localparam int OP_W    = 2;
  localparam int IDX_W   = 4;
  localparam int MASK_W  = 16;

endpackage

// ===== rtl/lru_block_replacement.sv =====
// ----------------------------------------------------------------------------
// LRU block replacement
// Keeps a recency order over NUM_BLOCKS cache blocks and picks victims.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transaction is taken on a rising edge with start high
//   and busy low. busy is always low, so one transaction per cycle.
//   operation selects touch (block_index becomes most recently used),
//   replace (lowest invalid block in valid_mask, else the least recently
//   used block, is chosen and becomes most recently used) or clear (order
//   returns to block-index order). Code 3 changes nothing.
//   Result channel: done is high for exactly one cycle per transaction with
//   victim_index and victim_was_free (both zero except for replace).
//   Each transaction passes the command register, then the rank update and
//   the result register, before its result is shown on the result channel.
//   Throughput: 1 transaction per cycle; the rank update of one transaction
//   completes on the same edge the next one enters the command register.
//   Reset: ranks return to block-index order, no result pending.
//   The receiver cannot stall; every result is shown for one cycle only.
// ----------------------------------------------------------------------------
module lru_block_replacement
  import lrubr_pkg::*;
#(
  parameter int NUM_BLOCKS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation,
  input  logic [IDX_W-1:0]  block_index,
  input  logic [MASK_W-1:0] valid_mask,
  output logic              done,
  output logic [IDX_W-1:0]  victim_index,
  output logic              victim_was_free
);

  localparam int BLK_W  = $clog2(NUM_BLOCKS);
  localparam int FREE_N = (NUM_BLOCKS < MASK_W) ? NUM_BLOCKS : MASK_W;
  localparam logic [BLK_W-1:0] NEWEST = BLK_W'(NUM_BLOCKS - 1);

  logic              s1_valid;
  op_t               s1_op;
  logic [IDX_W-1:0]  s1_idx;
  logic [MASK_W-1:0] s1_mask;

  logic [BLK_W-1:0]  rank [NUM_BLOCKS];
  logic [BLK_W-1:0]  rank_next [NUM_BLOCKS];

  logic              free_found;
  logic [BLK_W-1:0]  free_idx;
  logic [BLK_W-1:0]  lru_idx;
  logic [BLK_W-1:0]  target;
  logic              target_en;
  logic [BLK_W-1:0]  old_rank;
  logic [IDX_W-1:0]  victim_index_next;
  logic              victim_was_free_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
    if (start && !busy) begin
      s1_op   <= op_t'(operation);
      s1_idx  <= block_index;
      s1_mask <= valid_mask;
    end
  end

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FREE_N - 1; i >= 0; i--) begin
      if (!s1_mask[i]) begin
        free_found = 1'b1;
        free_idx   = BLK_W'(i);
      end
    end
  end

  always_comb begin
    lru_idx = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (rank[i] == '0) begin
        lru_idx = lru_idx | BLK_W'(i);
      end
    end
  end

  always_comb begin
    target               = '0;
    target_en            = 1'b0;
    victim_index_next    = '0;
    victim_was_free_next = 1'b0;
    if (s1_valid) begin
      unique case (s1_op)
        OP_TOUCH: begin
          target_en = (32'(s1_idx) < NUM_BLOCKS);
          target    = BLK_W'(s1_idx);
        end
        OP_REPLACE: begin
          target_en            = 1'b1;
          target               = free_found ? free_idx : lru_idx;
          victim_index_next    = IDX_W'(target);
          victim_was_free_next = free_found;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    old_rank = '0;
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      if (target == BLK_W'(i)) begin
        old_rank = old_rank | rank[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      rank_next[i] = rank[i];
      if (s1_valid && s1_op == OP_CLEAR) begin
        rank_next[i] = BLK_W'(i);
      end else if (s1_valid && target_en) begin
        if (target == BLK_W'(i)) begin
          rank_next[i] = NEWEST;
        end else if (rank[i] > old_rank) begin
          rank_next[i] = rank[i] - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        rank[i] <= BLK_W'(i);
      end
      done <= 1'b0;
    end else begin
      for (int i = 0; i < NUM_BLOCKS; i++) begin
        rank[i] <= rank_next[i];
      end
      done <= s1_valid;
    end
    victim_index    <= victim_index_next;
    victim_was_free <= victim_was_free_next;
  end

  a_free_needs_done: assert property (@(posedge clk) disable iff (rst)
    victim_was_free |-> done)
    else $error("free victim flagged without a result");

  a_free_from_replace: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op != OP_REPLACE) |=> (victim_index == '0 && !victim_was_free))
    else $error("nonzero result for a non-replace transaction");

  a_clear_order: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_op == OP_CLEAR) |=> (rank[0] == '0 && lru_idx == '0))
    else $error("clear did not restore block-index order");

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> done)
    else $error("transaction produced no result");

endmodule
